[src/fppc8_pkg.sv]
// Shared constants, codes and the CRC-8 byte update for the packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package fppc8_pkg;

    // Store depth default
    localparam int FPPC8_MAX_PAYLOAD = 64;

    // Result status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_PACKET  = 2'd1;
    localparam logic [1:0] ST_FORMAT  = 2'd2;
    localparam logic [1:0] ST_CRC_ERR = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [1:0] CFG_LENGTH_LIMIT  = 2'd2;

    // Configuration reset values
    localparam logic [7:0] RST_HEADER_FIRST  = 8'hAA;
    localparam logic [7:0] RST_HEADER_SECOND = 8'h55;
    localparam logic [6:0] RST_LENGTH_LIMIT  = 7'd64;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // One byte through CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] din);
        logic [7:0] v;
        v = crc ^ din;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = (v << 1) ^ CRC_POLY;
            end else begin
                v = v << 1;
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[src/framed_packet_parser_crc8.sv]
// Byte-serial frame deframer with CRC-8 check and payload store.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                     Content
// rx        in   s_axis_tvalid/s_axis_tready   tdata[7:0] rx_byte
// result    out  m_axis_tvalid/m_axis_tready   tuser status, tlast last, tdata frame fields
// config    in   i_cfg_we (no wait)            i_cfg_addr index, i_cfg_data value
//
// Each accepted byte yields one result item in the output register, except the
// good CRC byte of a non-empty frame. Such a frame with N payload bytes then
// emits N items, one payload store read plus one output load per item; no byte is
// taken meanwhile. Reset is synchronous, active low, and needs no clearing pass.
// A stalled output holds its item and holds off the input.

module framed_packet_parser_crc8
    import fppc8_pkg::*;
#(
    parameter int MAX_PAYLOAD = FPPC8_MAX_PAYLOAD
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_data,
    // receive stream
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [47:0] m_axis_tdata,   // [7:0] frame_version, [15:8] frame_type,
                                             // [22:16] frame_length, [30:23] frame_sequence,
                                             // [38:31] payload_byte, [44:39] payload_position,
                                             // [47:45] zero
    output      logic [1:0]  m_axis_tuser,   // [1:0] status
    output      logic        m_axis_tlast
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [3:0] {
        S_HDR0,
        S_HDR1,
        S_VER,
        S_TYPE,
        S_LEN,
        S_SEQ,
        S_PAY,
        S_CRC,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state          r_state;

    // configuration
    logic [7:0]      r_header_first;
    logic [7:0]      r_header_second;
    logic [6:0]      r_length_limit;

    // frame context
    logic [7:0]      r_crc;
    logic [CW-1:0]   r_byte_count;
    logic [CW-1:0]   r_emit_idx;
    logic [7:0]      r_held_version;
    logic [7:0]      r_held_type;
    logic [6:0]      r_held_length;
    logic [7:0]      r_held_sequence;

    // output register
    logic            r_out_valid;
    logic [1:0]      r_out_status;
    logic [7:0]      r_out_version;
    logic [7:0]      r_out_type;
    logic [6:0]      r_out_length;
    logic [7:0]      r_out_sequence;
    logic [7:0]      r_out_byte;
    logic [5:0]      r_out_position;
    logic            r_out_last;

    // output register next values
    logic            n_out_valid;
    logic [1:0]      n_out_status;
    logic [7:0]      n_out_version;
    logic [7:0]      n_out_type;
    logic [6:0]      n_out_length;
    logic [7:0]      n_out_sequence;
    logic [7:0]      n_out_byte;
    logic [5:0]      n_out_position;
    logic            n_out_last;

    // payload store
    logic [7:0]      r_store [MAX_PAYLOAD];
    logic [7:0]      r_rd_data;

    logic            out_free;
    logic            in_accept;
    logic [7:0]      rx;
    logic [6:0]      eff_limit;
    logic            len_bad;
    logic [7:0]      crc_next;
    logic            mem_we;
    logic            mem_re;
    logic            emit_last;
    logic [6:0]      pay_count_next;
    logic            crc_good_run;

    assign rx        = s_axis_tdata;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign s_axis_tready = out_free && (r_state != S_EMIT_RD) && (r_state != S_EMIT_LD);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign eff_limit = (r_length_limit > 7'(MAX_PAYLOAD)) ? 7'(MAX_PAYLOAD) : r_length_limit;
    assign len_bad   = rx > {1'b0, eff_limit};
    // version byte starts the CRC from zero
    assign crc_next  = crc8_step((r_state == S_VER) ? 8'h00 : r_crc, rx);

    assign pay_count_next = 7'(r_byte_count) + 7'd1;
    assign emit_last      = (7'(r_emit_idx) + 7'd1) == r_held_length;

    // good CRC of a non-empty frame: the items come from the emit loop instead
    assign crc_good_run = (r_state == S_CRC) && (r_crc == rx) && (r_held_length != 7'd0);

    // Store writes happen only while collecting payload, reads only while
    // emitting, so the two never touch the same entry in one cycle.
    assign mem_we = in_accept && (r_state == S_PAY);
    assign mem_re = (r_state == S_EMIT_RD);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_byte_count[AW-1:0]] <= rx;
        end
        if (mem_re) begin
            r_rd_data <= r_store[r_emit_idx[AW-1:0]];
        end
    end

    // config writes; an unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= RST_HEADER_FIRST;
            r_header_second <= RST_HEADER_SECOND;
            r_length_limit  <= RST_LENGTH_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_HEADER_FIRST:  r_header_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_header_second <= i_cfg_data;
                CFG_LENGTH_LIMIT:  r_length_limit  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // next contents of the output register
    always_comb begin
        n_out_valid    = r_out_valid && !m_axis_tready;
        n_out_status   = r_out_status;
        n_out_version  = r_out_version;
        n_out_type     = r_out_type;
        n_out_length   = r_out_length;
        n_out_sequence = r_out_sequence;
        n_out_byte     = r_out_byte;
        n_out_position = r_out_position;
        n_out_last     = r_out_last;
        if (in_accept && !crc_good_run) begin
            // every byte but a good CRC of a non-empty frame gives one plain item
            n_out_valid    = 1'b1;
            n_out_status   = ST_NONE;
            n_out_version  = 8'h00;
            n_out_type     = 8'h00;
            n_out_length   = 7'd0;
            n_out_sequence = 8'h00;
            n_out_byte     = 8'h00;
            n_out_position = 6'd0;
            n_out_last     = 1'b1;
            case (r_state)
                S_LEN: begin
                    if (len_bad) begin
                        n_out_status = ST_FORMAT;
                    end
                end
                S_CRC: begin
                    if (r_crc != rx) begin
                        n_out_status = ST_CRC_ERR;
                    end else begin
                        // empty payload: one item with the header fields
                        n_out_status   = ST_PACKET;
                        n_out_version  = r_held_version;
                        n_out_type     = r_held_type;
                        n_out_sequence = r_held_sequence;
                    end
                end
                default: ;
            endcase
        end else if (r_state == S_EMIT_LD && out_free) begin
            n_out_valid    = 1'b1;
            n_out_status   = ST_PACKET;
            n_out_version  = r_held_version;
            n_out_type     = r_held_type;
            n_out_length   = r_held_length;
            n_out_sequence = r_held_sequence;
            n_out_byte     = r_rd_data;
            n_out_position = 6'(r_emit_idx);
            n_out_last     = emit_last;
        end
    end

    // parser state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HDR0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid    <= n_out_valid;
            r_out_status   <= n_out_status;
            r_out_version  <= n_out_version;
            r_out_type     <= n_out_type;
            r_out_length   <= n_out_length;
            r_out_sequence <= n_out_sequence;
            r_out_byte     <= n_out_byte;
            r_out_position <= n_out_position;
            r_out_last     <= n_out_last;

            case (r_state)
                S_HDR0: begin
                    if (in_accept && rx == r_header_first) begin
                        r_state <= S_HDR1;
                    end
                end
                S_HDR1: begin
                    if (in_accept) begin
                        // second header wins when both headers match
                        if (rx == r_header_second) begin
                            r_state <= S_VER;
                        end else if (rx != r_header_first) begin
                            r_state <= S_HDR0;
                        end
                    end
                end
                S_VER: begin
                    if (in_accept) begin
                        r_held_version <= rx;
                        r_crc          <= crc_next;
                        r_state        <= S_TYPE;
                    end
                end
                S_TYPE: begin
                    if (in_accept) begin
                        r_held_type <= rx;
                        r_crc       <= crc_next;
                        r_state     <= S_LEN;
                    end
                end
                S_LEN: begin
                    if (in_accept) begin
                        r_crc <= crc_next;
                        if (len_bad) begin
                            r_state <= (rx == r_header_first) ? S_HDR1 : S_HDR0;
                        end else begin
                            r_held_length <= rx[6:0];
                            r_state       <= S_SEQ;
                        end
                    end
                end
                S_SEQ: begin
                    if (in_accept) begin
                        r_held_sequence <= rx;
                        r_crc           <= crc_next;
                        r_byte_count    <= '0;
                        r_state         <= (r_held_length == 7'd0) ? S_CRC : S_PAY;
                    end
                end
                S_PAY: begin
                    if (in_accept) begin
                        r_byte_count <= CW'(r_byte_count + 1'b1);
                        r_crc        <= crc_next;
                        if (pay_count_next >= r_held_length) begin
                            r_state <= S_CRC;
                        end
                    end
                end
                S_CRC: begin
                    if (in_accept) begin
                        if (r_crc != rx) begin
                            r_state <= (rx == r_header_first) ? S_HDR1 : S_HDR0;
                        end else if (r_held_length == 7'd0) begin
                            r_state <= S_HDR0;
                        end else begin
                            r_emit_idx <= '0;
                            r_state    <= S_EMIT_RD;
                        end
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    if (out_free) begin
                        if (emit_last) begin
                            r_state <= S_HDR0;
                        end else begin
                            r_emit_idx <= CW'(r_emit_idx + 1'b1);
                            r_state    <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_HDR0;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {3'b000, r_out_position, r_out_byte, r_out_sequence,
                            r_out_length, r_out_type, r_out_version};

`ifndef SYNTHESIS
    // an accepted byte other than a good CRC of a non-empty frame leaves an item in the output register
    a_accept_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !crc_good_run |=> m_axis_tvalid)
        else $error("accepted byte left no result item");

    // only packet items may be part of a multi-item run
    a_single_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_PACKET |-> m_axis_tlast)
        else $error("non-packet item without last");

    // input held off while the payload is read out
    a_no_accept_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_RD || r_state == S_EMIT_LD) |-> !s_axis_tready)
        else $error("byte accepted during payload emission");

    // payload count stays inside the declared length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PAY |-> 7'(r_byte_count) < r_held_length)
        else $error("payload count beyond frame length");
`endif

endmodule

`default_nettype wire

[dv/fppc8_checker.sv]
// Stream monitor, frame predictor and result scoreboard for the packet deframer.
`timescale 1ns / 1ps

module fppc8_checker
    import fppc8_pkg::*;
#(
    parameter int MAX_PAYLOAD = FPPC8_MAX_PAYLOAD
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_rx_tvalid,
    input  wire logic        i_rx_tready,
    input  wire logic [7:0]  i_rx_tdata,    // [7:0] rx_byte
    input  wire logic        i_res_tvalid,
    input  wire logic        i_res_tready,
    input  wire logic [47:0] i_res_tdata,   // [7:0] version, [15:8] type, [22:16] length,
                                            // [30:23] sequence, [38:31] payload byte,
                                            // [44:39] position, [47:45] zero
    input  wire logic [1:0]  i_res_tuser,   // [1:0] status
    input  wire logic        i_res_tlast,
    output int               o_mismatches,
    output int               o_outstanding
);

    localparam int REPORT_CAP = 40;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] version;
        logic [7:0] ftype;
        logic [6:0] length;
        logic [7:0] seq_no;
        logic [7:0] pbyte;
        logic [5:0] pos;
        logic       last;
    } frame_item_t;

    typedef enum logic [2:0] {
        WANT_FIRST, WANT_SECOND, WANT_VERSION, WANT_TYPE,
        WANT_LENGTH, WANT_SEQUENCE, WANT_PAYLOAD, WANT_CRC
    } parse_step_e;

    parse_step_e step;
    logic [6:0]  got_count;
    logic [7:0]  crc_acc;
    logic [7:0]  hold_ver, hold_type, hold_seq;
    logic [6:0]  hold_len;
    logic [7:0]  payload_mem [MAX_PAYLOAD];
    logic [7:0]  hdr_first, hdr_second;
    logic [6:0]  len_limit;

    frame_item_t expected_items [$];
    int          errors = 0;
    string       field_names [9] = '{"status", "frame_version", "frame_type", "frame_length",
                                     "frame_sequence", "payload_byte", "payload_position",
                                     "last", "tdata_pad"};

    // CRC-8, poly 0x07, MSB first
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] din);
        logic [7:0] r;
        r = acc ^ din;
        repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        return r;
    endfunction

    function automatic frame_item_t lone_item(input logic [1:0] status);
        frame_item_t it;
        it = '0;
        it.status = status;
        it.last = 1'b1;
        return it;
    endfunction

    // after a length or CRC error the current byte may open the next frame
    task automatic restart_hunt(input logic [7:0] b);
        step = (b == hdr_first) ? WANT_SECOND : WANT_FIRST;
        got_count = '0;
        crc_acc = '0;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        int lim;
        frame_item_t it;
        lim = (int'(len_limit) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len_limit);
        case (step)
            WANT_FIRST: begin
                if (b == hdr_first) step = WANT_SECOND;
                expected_items.push_back(lone_item(ST_NONE));
            end
            WANT_SECOND: begin
                // second header wins when both headers are equal
                if (b == hdr_second) begin
                    step = WANT_VERSION;
                    got_count = '0;
                    crc_acc = '0;
                end else if (b != hdr_first) begin
                    step = WANT_FIRST;
                end
                expected_items.push_back(lone_item(ST_NONE));
            end
            WANT_VERSION: begin
                hold_ver = b;
                crc_acc = crc8_next(8'h00, b);
                step = WANT_TYPE;
                expected_items.push_back(lone_item(ST_NONE));
            end
            WANT_TYPE: begin
                hold_type = b;
                crc_acc = crc8_next(crc_acc, b);
                step = WANT_LENGTH;
                expected_items.push_back(lone_item(ST_NONE));
            end
            WANT_LENGTH: begin
                crc_acc = crc8_next(crc_acc, b);
                if (int'(b) > lim) begin
                    restart_hunt(b);
                    expected_items.push_back(lone_item(ST_FORMAT));
                end else begin
                    hold_len = b[6:0];
                    step = WANT_SEQUENCE;
                    expected_items.push_back(lone_item(ST_NONE));
                end
            end
            WANT_SEQUENCE: begin
                hold_seq = b;
                crc_acc = crc8_next(crc_acc, b);
                got_count = '0;
                step = (hold_len == 0) ? WANT_CRC : WANT_PAYLOAD;
                expected_items.push_back(lone_item(ST_NONE));
            end
            WANT_PAYLOAD: begin
                if (got_count < MAX_PAYLOAD) payload_mem[got_count] = b;
                got_count = got_count + 7'd1;
                crc_acc = crc8_next(crc_acc, b);
                if (got_count >= hold_len) step = WANT_CRC;
                expected_items.push_back(lone_item(ST_NONE));
            end
            default: begin
                if (crc_acc != b) begin
                    restart_hunt(b);
                    expected_items.push_back(lone_item(ST_CRC_ERR));
                end else begin
                    it = lone_item(ST_PACKET);
                    it.version = hold_ver;
                    it.ftype = hold_type;
                    it.seq_no = hold_seq;
                    if (hold_len == 0) begin
                        expected_items.push_back(it);
                    end else begin
                        for (int k = 0; k < hold_len; k++) begin
                            it.length = hold_len;
                            it.pbyte = payload_mem[k];
                            it.pos = k[5:0];
                            it.last = (k + 1 == hold_len);
                            expected_items.push_back(it);
                        end
                    end
                    // good frame: CRC byte never reused as a header
                    step = WANT_FIRST;
                    got_count = '0;
                    crc_acc = '0;
                end
            end
        endcase
    endtask

    task automatic check_item();
        frame_item_t want;
        logic [7:0]  want_f [9];
        logic [7:0]  got_f [9];
        if (expected_items.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
                $error("result item with nothing expected: tuser %0d tdata %h",
                       i_res_tuser, i_res_tdata);
            return;
        end
        want = expected_items.pop_front();
        want_f = '{8'(want.status), want.version, want.ftype, 8'(want.length), want.seq_no,
                   want.pbyte, 8'(want.pos), 8'(want.last), 8'h00};
        got_f = '{8'(i_res_tuser), i_res_tdata[7:0], i_res_tdata[15:8],
                  8'(i_res_tdata[22:16]), i_res_tdata[30:23], i_res_tdata[38:31],
                  8'(i_res_tdata[44:39]), 8'(i_res_tlast), 8'(i_res_tdata[47:45])};
        for (int f = 0; f < 9; f++) begin
            if (want_f[f] !== got_f[f]) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $error("%s: expected %0d, actual %0d", field_names[f], want_f[f], got_f[f]);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hdr_first = RST_HEADER_FIRST;
            hdr_second = RST_HEADER_SECOND;
            len_limit = RST_LENGTH_LIMIT;
            step = WANT_FIRST;
            got_count = '0;
            crc_acc = '0;
            hold_ver = '0;
            hold_type = '0;
            hold_len = '0;
            hold_seq = '0;
            expected_items.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_HEADER_FIRST:  hdr_first = i_cfg_data;
                    CFG_HEADER_SECOND: hdr_second = i_cfg_data;
                    CFG_LENGTH_LIMIT:  len_limit = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            // output is registered, so a result never belongs to the byte taken at this edge
            if (i_res_tvalid && i_res_tready) check_item();
            if (i_rx_tvalid && i_rx_tready) predict_byte(i_rx_tdata);
        end
        o_mismatches <= errors;
        o_outstanding <= expected_items.size();
    end

endmodule

[dv/tb_framed_packet_parser_crc8.sv]
// Top-level bench: byte stimulus, result back-pressure and verdict for the deframer.
`timescale 1ns / 1ps

module tb_framed_packet_parser_crc8;
    import fppc8_pkg::*;

    // Longest quiet stretch of a correct run is a receiver stall plus a sender gap
    // and a config pause; this is many times that.
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_BYTES  = 22;    // random bytes per configuration phase
    localparam int SETTLE_TICKS = 6;     // output register plus margin

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = CFG_HEADER_FIRST;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] rx_byte
    logic        m_axis_tready = 1'b0;
    wire logic        s_axis_tready;
    wire logic        m_axis_tvalid;
    wire logic [47:0] m_axis_tdata;        // [7:0] version .. [44:39] position, [47:45] zero
    wire logic [1:0]  m_axis_tuser;        // [1:0] status
    wire logic        m_axis_tlast;

    int mismatch_total;
    int results_owed;

    // stimulus-side copy of the register file, used to shape frames
    logic [7:0] hdr_a = RST_HEADER_FIRST;
    logic [7:0] hdr_b = RST_HEADER_SECOND;
    int         tb_limit = int'(RST_LENGTH_LIMIT);

    int burst_left = 0;
    int sent_bytes = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    framed_packet_parser_crc8 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    fppc8_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_rx_tvalid   (s_axis_tvalid),
        .i_rx_tready   (s_axis_tready),
        .i_rx_tdata    (s_axis_tdata),
        .i_res_tvalid  (m_axis_tvalid),
        .i_res_tready  (m_axis_tready),
        .i_res_tdata   (m_axis_tdata),
        .i_res_tuser   (m_axis_tuser),
        .i_res_tlast   (m_axis_tlast),
        .o_mismatches  (mismatch_total),
        .o_outstanding (results_owed)
    );

    // Receiver back-pressure: a 32-slot ready mask, reloaded after each pass through its slots.
    // Modes: always ready, half, mostly ready, mostly stalled.
    logic [31:0] ready_mask = '1;
    int          ready_slot = 0;

    always @(posedge i_clk) begin
        if (ready_slot == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_mask = '1;
                1:       ready_mask = $urandom();
                2:       ready_mask = $urandom() | $urandom();
                default: ready_mask = $urandom() & $urandom();
            endcase
        end
        m_axis_tready <= ready_mask[ready_slot];
        ready_slot = (ready_slot + 1) % 32;
    end

    // Watchdog: any handshake, config write or reset clears it.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // biased byte: extremes a third of the time
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // One item on the rx channel. Sender runs in bursts; a gap drops tvalid between
    // bursts, and some bursts are long stretches with no gap at all.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(40, 120);
            end else begin
                gap = $urandom_range(1, 8);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge i_clk);
        burst_left--;
        sent_bytes++;
    endtask

    // Quiesce: stop sending, wait for every owed result, then let the output settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [7:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (addr)
            CFG_HEADER_FIRST:  hdr_a = data;
            CFG_HEADER_SECOND: hdr_b = data;
            CFG_LENGTH_LIMIT:  tb_limit = int'(data[6:0]);
            default: ;
        endcase
    endtask

    // One frame. Stops after the length byte when the length is over the limit.
    //   skip_first : leave out the first header (parser already waiting for the second)
    //   crc_flip   : xor into the CRC byte, 0 for a good frame
    //   force_crc  : >= 0 picks the last payload byte so the true CRC equals this value
    //   crc_as     : >= 0 sends this byte in place of the CRC
    task automatic send_frame(input int len, input bit skip_first, input logic [7:0] crc_flip,
                              input int force_crc, input int crc_as);
        logic [7:0] crc;
        logic [7:0] b;
        int         lim;
        lim = (tb_limit > FPPC8_MAX_PAYLOAD) ? FPPC8_MAX_PAYLOAD : tb_limit;
        if (!skip_first) push_byte(hdr_a);
        push_byte(hdr_b);
        b = pick_byte();                    // version
        crc = crc8_step(8'h00, b);
        push_byte(b);
        b = pick_byte();                    // type
        crc = crc8_step(crc, b);
        push_byte(b);
        b = len[7:0];                       // length
        crc = crc8_step(crc, b);
        push_byte(b);
        if (len > lim) return;
        b = pick_byte();                    // sequence
        crc = crc8_step(crc, b);
        push_byte(b);
        for (int k = 0; k < len; k++) begin
            b = pick_byte();
            if (k == len - 1 && force_crc >= 0) begin
                for (int v = 0; v < 256; v++)
                    if (crc8_step(crc, v[7:0]) == force_crc[7:0]) b = v[7:0];
            end
            crc = crc8_step(crc, b);
            push_byte(b);
        end
        push_byte((crc_as >= 0) ? crc_as[7:0] : (crc ^ crc_flip));
    endtask

    // Random traffic: mostly good frames with short payloads, the rest broken frames
    // and line noise.
    task automatic random_traffic();
        int sel;
        int lim;
        int short_max;
        lim = (tb_limit > FPPC8_MAX_PAYLOAD) ? FPPC8_MAX_PAYLOAD : tb_limit;
        short_max = (lim < 8) ? lim : 8;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            send_frame(($urandom_range(0, 19) == 0) ? lim : $urandom_range(0, short_max),
                       1'b0, 8'h00, -1, -1);
        end else if (sel < 70) begin
            send_frame($urandom_range(0, short_max), 1'b0, 8'($urandom_range(1, 255)), -1, -1);
        end else if (sel < 78) begin
            send_frame($urandom_range(lim + 1, 255), 1'b0, 8'h00, -1, -1);
        end else if (sel < 85) begin
            push_byte(hdr_a);               // repeated first header
            send_frame($urandom_range(0, short_max), 1'b0, 8'h00, -1, -1);
        end else if (sel < 92) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom()));
        end else begin
            push_byte(hdr_a);               // header then junk
            push_byte(8'($urandom()));
        end
    endtask

    initial begin
        int stop_at;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed, reset configuration (AA / 55 / 64) ----
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(hdr_a);
        push_byte(8'h13);                                   // broken header: back to hunt
        send_frame(0, 1'b0, 8'h00, -1, -1);                 // empty payload
        send_frame(1, 1'b0, 8'h00, -1, -1);
        push_byte(hdr_a);                                   // repeated first header
        send_frame(3, 1'b0, 8'h00, -1, -1);
        send_frame(64, 1'b0, 8'h00, -1, -1);                // full store
        send_frame(65, 1'b0, 8'h00, -1, -1);                // one over the limit
        send_frame(255, 1'b0, 8'h00, -1, -1);
        // length byte equal to the first header: format error, then resync on it
        send_frame(int'(hdr_a), 1'b0, 8'h00, -1, -1);
        send_frame(2, 1'b1, 8'h00, -1, -1);
        send_frame(4, 1'b0, 8'h01, -1, -1);                 // bad CRC
        // bad CRC byte equal to the first header: resync on it
        send_frame(2, 1'b0, 8'h00, -1, int'(hdr_a));
        send_frame(0, 1'b1, 8'h00, -1, -1);
        // good frame whose CRC equals the first header: must not start a frame
        send_frame(3, 1'b0, 8'h00, int'(hdr_a), -1);
        push_byte(hdr_b);
        send_frame(1, 1'b0, 8'h00, -1, -1);

        // ---- limit register above store depth: effective limit stays 64 ----
        drain();
        write_reg(CFG_LENGTH_LIMIT, 8'hFF);
        send_frame(64, 1'b0, 8'h00, -1, -1);
        send_frame(65, 1'b0, 8'h00, -1, -1);
        send_frame(127, 1'b0, 8'h00, -1, -1);

        // ---- equal header bytes, zero limit ----
        drain();
        write_reg(CFG_HEADER_FIRST, 8'h5A);
        write_reg(CFG_HEADER_SECOND, 8'h5A);
        write_reg(CFG_LENGTH_LIMIT, 8'h00);
        send_frame(0, 1'b0, 8'h00, -1, -1);
        send_frame(1, 1'b0, 8'h00, -1, -1);                 // format error on any payload
        push_byte(8'h5A);
        send_frame(0, 1'b0, 8'h00, -1, -1);

        // ---- random phases over several register settings ----
        for (int p = 0; p < 4; p++) begin
            drain();
            case (p)
                0: begin
                    write_reg(CFG_HEADER_FIRST, 8'h00);
                    write_reg(CFG_HEADER_SECOND, 8'hFF);
                    write_reg(CFG_LENGTH_LIMIT, 8'd64);
                end
                1: begin
                    write_reg(CFG_HEADER_FIRST, 8'hFF);
                    write_reg(CFG_HEADER_SECOND, 8'hFF);
                    write_reg(CFG_LENGTH_LIMIT, 8'd0);
                end
                2: begin
                    write_reg(CFG_HEADER_FIRST, 8'($urandom()));
                    write_reg(CFG_HEADER_SECOND, 8'($urandom()));
                    write_reg(CFG_LENGTH_LIMIT, 8'd1);
                end
                default: begin
                    write_reg(CFG_HEADER_FIRST, 8'($urandom()));
                    write_reg(CFG_HEADER_SECOND, 8'($urandom()));
                    write_reg(CFG_LENGTH_LIMIT, 8'($urandom_range(2, 127)));
                end
            endcase
            stop_at = sent_bytes + PHASE_BYTES;
            while (sent_bytes < stop_at) random_traffic();
        end

        drain();
        if (mismatch_total == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[sim.f]
src/fppc8_pkg.sv
src/framed_packet_parser_crc8.sv
dv/fppc8_checker.sv
dv/tb_framed_packet_parser_crc8.sv
